FILE: rtl/csp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing pass package
// Shared constants, types and the 4-5 smoothing rule for the cave smoothing
// pass block.
// ----------------------------------------------------------------------------
package csp_pkg;

    // Width of the grid size registers.
    localparam int CFG_W = 9;
    // Width of the row and column fields of a result.
    localparam int OUT_W = 8;
    // APB port widths.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Smallest legal grid size and the thresholds of the smoothing rule.
    localparam int SIZE_MIN  = 3;
    localparam int ROCK_MIN  = 5;
    localparam int FLOOR_MAX = 3;

    // Register index, taken from paddr bit 2.
    typedef enum logic [0:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_grid_cfg;

    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             is_rock;
        logic             last;
    } t_result;

    // Limits a written size to the range SIZE_MIN..hi.
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int hi);
        logic [CFG_W-1:0] res;
        if (int'(v) < SIZE_MIN) begin
            res = CFG_W'(SIZE_MIN);
        end else if (int'(v) > hi) begin
            res = CFG_W'(hi);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // New value of a cell from its eight neighbors and its own value.
    function automatic logic smooth_rule(input logic [7:0] nbrs, input logic centre);
        logic [3:0] cnt;
        logic       res;
        cnt = '0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'b000, nbrs[k]};
        end
        if (int'(cnt) >= ROCK_MIN) begin
            res = 1'b1;
        end else if (int'(cnt) <= FLOOR_MAX) begin
            res = 1'b0;
        end else begin
            res = centre;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/csp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing configuration registers
// APB slave holding the clamped grid width and height.
// ----------------------------------------------------------------------------
module csp_cfg
    import csp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_grid_cfg              o_cfg,
    output logic                   o_wr
);

    t_grid_cfg r_cfg;
    t_reg_idx  idx;

    assign idx    = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign o_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= clamp_size(CFG_W'(256), MAX_WIDTH);
            r_cfg.height <= clamp_size(CFG_W'(256), MAX_HEIGHT);
        end else if (o_wr) begin
            case (idx)
                REG_GRID_WIDTH:  r_cfg.width  <= clamp_size(pwdata[CFG_W-1:0], MAX_WIDTH);
                REG_GRID_HEIGHT: r_cfg.height <= clamp_size(pwdata[CFG_W-1:0], MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GRID_WIDTH:  prdata = APB_DW'(r_cfg.width);
            REG_GRID_HEIGHT: prdata = APB_DW'(r_cfg.height);
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/csp_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing line store
// One-bit-wide row memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module csp_line_store #(
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic                     i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic                          o_rd_data
);

    logic r_mem [DEPTH];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/csp_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing core
// Raster counters, 3x3 window registers and the smoothing rule. Drives the
// line store addresses and produces one result per interior cell.
// ----------------------------------------------------------------------------
module csp_core
    import csp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_grid_cfg                    i_cfg,
    input  wire logic                         i_cfg_wr,
    input  wire logic                         i_accept,
    input  wire logic                         i_cell,
    input  wire logic                         i_raw_q,
    input  wire logic                         i_fin_q,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_rd_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_raw_wr_addr,
    output logic                              o_raw_wr_data,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_fin_wr_addr,
    output logic                              o_fin_wr_data,
    output logic                              o_produce,
    output t_result                           o_result
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ((CW > RW ? CW : RW) + 1 > CFG_W) ?
                           (CW > RW ? CW : RW) + 1 : CFG_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // Window columns left of the arriving one: a is two back, b is one back.
    logic r_ua, r_ub, r_ma, r_mb, r_la, r_lb;
    // Raw last-column value of the middle row, written to the final store later.
    logic r_hold;

    logic last_col, last_row, nv;

    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(i_cfg.width);
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(i_cfg.height);
    assign o_produce = (int'(r_row) >= 2) && (int'(r_col) >= 2);

    assign nv = smooth_rule({r_ua, r_ub, i_fin_q, r_ma, i_raw_q, r_la, r_lb, i_cell}, r_mb);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    assign o_rd_addr     = n_col;
    assign o_raw_wr_addr = r_col;
    assign o_raw_wr_data = i_cell;

    // The middle row's cell one column back is final once this step is done;
    // the last column is filled in at the start of the next row.
    always_comb begin
        if (r_col == '0) begin
            o_fin_wr_addr = CW'(i_cfg.width - CFG_W'(1));
            o_fin_wr_data = r_hold;
        end else begin
            o_fin_wr_addr = r_col - CW'(1);
            o_fin_wr_data = o_produce ? nv : r_mb;
        end
    end

    always_comb begin
        o_result.row     = OUT_W'(32'(r_row) - 32'd1);
        o_result.col     = OUT_W'(32'(r_col) - 32'd1);
        o_result.is_rock = nv;
        o_result.last    = last_row && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ua <= r_ub;
            r_ub <= i_fin_q;
            r_ma <= o_produce ? nv : r_mb;
            r_mb <= i_raw_q;
            r_la <= r_lb;
            r_lb <= i_cell;
            if (last_col) begin
                r_hold <= i_raw_q;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/csp_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing output stage
// Result register with a skid entry so that input requests keep flowing
// while a result waits.
// ----------------------------------------------------------------------------
module csp_out_skid
    import csp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_out_v, r_sk_v;
    t_result r_out, r_sk;
    logic    take;

    assign take    = r_out_v & i_ready;
    assign o_ready = ~r_sk_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (take) begin
                r_sk_v <= 1'b0;
            end
        end else if (!r_out_v || take) begin
            r_out_v <= i_push;
        end else if (i_push) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (take) begin
                r_out <= r_sk;
            end
        end else if (!r_out_v || take) begin
            r_out <= i_data;
        end else if (i_push) begin
            r_sk <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/cave_smoothing_pass_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing pass
// One in-place pass of the 4-5 cellular automaton cave rule over a binary
// grid that streams in raster order, one cell per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                       Payload
//  input     in         i_in_valid / o_in_ready         i_cell_is_rock
//  output    out        o_out_valid / i_out_ready       o_out_row, o_out_col,
//                                                       o_new_is_rock, o_last_cell
//  config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
//  One cell is taken every cycle unless the skid entry is full; the request
//  that completes a window registers its result in the result register.
//  The rate is set by the two line stores, each read and written once per cell.
//  Reset (synchronous, active low) clears the counters and the output stage;
//  the line stores are not cleared and need no clearing pass.
//  A result that is not taken parks in a skid entry; input stalls only when
//  both the result register and the skid entry are full.
// ----------------------------------------------------------------------------
module cave_smoothing_pass_top
    import csp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Cell stream.
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_cell_is_rock,
    // Smoothed interior cells.
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [OUT_W-1:0]  o_out_row,
    output logic      [OUT_W-1:0]  o_out_col,
    output logic                   o_new_is_rock,
    output logic                   o_last_cell,
    // Configuration.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int CW = $clog2(MAX_WIDTH);

    t_grid_cfg     cfg;
    logic          cfg_wr;
    logic          accept;
    logic          raw_q, fin_q;
    logic [CW-1:0] rd_addr, raw_wr_addr, fin_wr_addr;
    logic          raw_wr_data, fin_wr_data;
    logic          produce;
    t_result       result, out_data;

    assign accept = i_in_valid & o_in_ready;

    csp_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_wr    (cfg_wr)
    );

    // Raw store: the row above the arriving one, as it arrived.
    csp_line_store #(.DEPTH(MAX_WIDTH)) u_raw_line (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (raw_wr_addr),
        .i_wr_data (raw_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (raw_q)
    );

    // Final store: the row two above the arriving one, with smoothed values.
    csp_line_store #(.DEPTH(MAX_WIDTH)) u_fin_line (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (fin_wr_addr),
        .i_wr_data (fin_wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (fin_q)
    );

    csp_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cfg_wr      (cfg_wr),
        .i_accept      (accept),
        .i_cell        (i_cell_is_rock),
        .i_raw_q       (raw_q),
        .i_fin_q       (fin_q),
        .o_rd_addr     (rd_addr),
        .o_raw_wr_addr (raw_wr_addr),
        .o_raw_wr_data (raw_wr_data),
        .o_fin_wr_addr (fin_wr_addr),
        .o_fin_wr_data (fin_wr_data),
        .o_produce     (produce),
        .o_result      (result)
    );

    csp_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept & produce),
        .i_data  (result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .i_ready (i_out_ready)
    );

    assign o_out_row     = out_data.row;
    assign o_out_col     = out_data.col;
    assign o_new_is_rock = out_data.is_rock;
    assign o_last_cell   = out_data.last;

endmodule
`default_nettype wire

FILE: rtl/csp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cave smoothing port checker
// Watches the ports of the top level for handshake and ordering slips.
// ----------------------------------------------------------------------------
module csp_checker
    import csp_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [OUT_W-1:0] o_out_row,
    input wire logic [OUT_W-1:0] o_out_col,
    input wire logic             o_new_is_rock,
    input wire logic             o_last_cell
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_row)
        && $stable(o_out_col) && $stable(o_new_is_rock) && $stable(o_last_cell))
        else $error("result changed while stalled");

    // A new result only follows an accepted cell.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result appeared without an accepted cell");

    // Input backpressure only comes from a waiting result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("output stage not cleared by reset");

endmodule

bind cave_smoothing_pass_top csp_checker u_csp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_row     (o_out_row),
    .o_out_col     (o_out_col),
    .o_new_is_rock (o_new_is_rock),
    .o_last_cell   (o_last_cell)
);
`default_nettype wire
